### hdl/bhd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bhd_pkg;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  // low nibble of 'a' or 'A' is 1, so value = low nibble + 9
  localparam logic [3:0] HEX_ALPHA_OFS = 4'd9;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // output queue entries
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    PH_PLAIN,
    PH_ESC,
    PH_HEX0,
    PH_HEX1
  } phase_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        run_last;
    logic        string_end;
    logic        bad_digit;
    logic        unknown_escape;
    logic [15:0] decoded_len;
  } result_t;

  typedef struct packed {
    phase_t phase;
    logic   count_zero;
  } dec_status_t;

  typedef struct packed {
    logic [QCNT_W-1:0] cnt;
  } q_status_t;

  // returns {bad, nibble}; a non-hex character counts as zero
  function automatic logic [4:0] nibble_of(logic [7:0] c);
    logic [4:0] res;
    if (c >= CH_0 && c <= CH_9) begin
      res = {1'b0, c[3:0]};
    end else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) begin
      res = {1'b0, c[3:0] + HEX_ALPHA_OFS};
    end else begin
      res = 5'b10000;
    end
    return res;
  endfunction

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    logic [15:0] res;
    if (v == COUNT_MAX) begin
      res = v;
    end else begin
      res = v + 16'd1;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### hdl/bhd_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module bhd_decode (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [7:0]           in_byte,
  input  wire logic                 in_final,
  input  wire logic                 step,
  output logic [1:0]                res_n,
  output bhd_pkg::result_t          res0,
  output bhd_pkg::result_t          res1,
  output bhd_pkg::dec_status_t      status
);
  import bhd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] cnt1, cnt2;
  logic [4:0]  nib_hi, nib_lo;

  assign cnt1   = sat_inc(count_r);
  assign cnt2   = sat_inc(cnt1);
  assign nib_hi = nibble_of(held_r);
  assign nib_lo = nibble_of(in_byte);

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    res_n     = 2'd0;
    res0      = '{out_byte: in_byte, run_last: 1'b0, string_end: 1'b0,
                  bad_digit: 1'b0, unknown_escape: 1'b0, decoded_len: cnt1};
    res1      = '{out_byte: in_byte, run_last: 1'b0, string_end: 1'b0,
                  bad_digit: 1'b0, unknown_escape: 1'b0, decoded_len: cnt2};
    case (phase_r)
      PH_PLAIN: begin
        if (in_byte == CH_BSLASH && !in_final) begin
          phase_nxt = PH_ESC;
        end else begin
          res_n = 2'd1;
        end
      end
      PH_ESC: begin
        phase_nxt = PH_PLAIN;
        if (in_byte == CH_BSLASH) begin
          res_n = 2'd1;
        end else if (in_byte == CH_X) begin
          if (in_final) begin
            res_n = 2'd1;
          end else begin
            phase_nxt = PH_HEX0;
          end
        end else begin
          // keep the backslash, then pass the character
          res_n               = 2'd2;
          res0.out_byte       = CH_BSLASH;
          res0.unknown_escape = 1'b1;
        end
      end
      PH_HEX0: begin
        if (in_final) begin
          // truncated escape: drop the backslash, pass 'x' and the digit
          res_n         = 2'd2;
          res0.out_byte = CH_X;
          phase_nxt     = PH_PLAIN;
        end else begin
          held_nxt  = in_byte;
          phase_nxt = PH_HEX1;
        end
      end
      PH_HEX1: begin
        res_n          = 2'd1;
        res0.out_byte  = {nib_hi[3:0], nib_lo[3:0]};
        res0.bad_digit = nib_hi[4] | nib_lo[4];
        held_nxt       = '0;
        phase_nxt      = PH_PLAIN;
      end
      default: begin
        phase_nxt = PH_PLAIN;
      end
    endcase

    if (res_n == 2'd1) begin
      res0.run_last   = 1'b1;
      res0.string_end = in_final;
    end else if (res_n == 2'd2) begin
      res1.run_last   = 1'b1;
      res1.string_end = in_final;
    end

    if (res_n == 2'd1) begin
      count_nxt = cnt1;
    end else if (res_n == 2'd2) begin
      count_nxt = cnt2;
    end else begin
      count_nxt = count_r;
    end

    if (in_final) begin
      phase_nxt = PH_PLAIN;
      held_nxt  = '0;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PLAIN;
      held_r  <= '0;
      count_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      count_r <= count_nxt;
    end
  end

  assign status = '{phase: phase_r, count_zero: (count_r == '0)};

endmodule

`default_nettype wire

### hdl/bhd_outq.sv
`timescale 1ns / 1ps
`default_nettype none

module bhd_outq (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [1:0]                    push_n,
  input  wire bhd_pkg::result_t              push0,
  input  wire bhd_pkg::result_t              push1,
  input  wire logic                          pop,
  output bhd_pkg::result_t                   head,
  output logic                               head_valid,
  output bhd_pkg::q_status_t                 status
);
  import bhd_pkg::*;

  result_t           e0_r, e0_nxt;
  result_t           e1_r, e1_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [QCNT_W-1:0] kcnt;
  result_t           k0;

  always_comb begin
    // drop the head first, then append new requests behind what is left
    if (pop && cnt_r != '0) begin
      k0   = e1_r;
      kcnt = cnt_r - QCNT_W'(1);
    end else begin
      k0   = e0_r;
      kcnt = cnt_r;
    end
    e0_nxt  = k0;
    e1_nxt  = e1_r;
    cnt_nxt = kcnt;
    case (kcnt)
      QCNT_W'(0): begin
        e0_nxt  = push0;
        e1_nxt  = push1;
        cnt_nxt = QCNT_W'(push_n);
      end
      QCNT_W'(1): begin
        e1_nxt  = push0;
        cnt_nxt = kcnt + QCNT_W'(push_n);
      end
      default: begin
        cnt_nxt = kcnt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

  assign head       = e0_r;
  assign head_valid = (cnt_r != '0);
  assign status     = '{cnt: cnt_r};

endmodule

`default_nettype wire

### hdl/backslash_hex_escape_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake             Payload
// in_      in   in_tvalid/in_tready   tdata[7:0] data_byte, tlast is_final
// out_     out  out_tvalid/out_tready tdata[7:0] out_byte, [23:8] decoded_len,
//                                     tlast run_last, tuser[2:0] flags
//
// One input byte is accepted per cycle when the output queue has room for the
// decoded bytes it yields; a byte that yields two decoded bytes takes two
// queue entries. The path is an input register, then decode into a
// two-entry output queue, whose free space sets when the input stage moves.
// Reset is synchronous, active low; it returns the escape phase to plain text
// and the count to zero. A stalled output backs up into in_tready.
module backslash_hex_escape_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // is_final
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] out_byte, [23:8] decoded_len
  output logic             out_tlast,  // run_last
  output logic [2:0]       out_tuser   // [0] string_end, [1] bad_digit, [2] unknown_escape
);
  import bhd_pkg::*;

  logic [7:0]  in_byte_r;
  logic        in_final_r;
  logic        s1_valid_r;
  logic        pop, adv;
  logic [2:0]  free_slots;
  logic [1:0]  res_n, push_n;
  result_t     res0, res1, head;
  logic        head_valid;
  dec_status_t dstat;
  q_status_t   qstat;

  bhd_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_byte  (in_byte_r),
    .in_final (in_final_r),
    .step     (adv),
    .res_n    (res_n),
    .res0     (res0),
    .res1     (res1),
    .status   (dstat)
  );

  bhd_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_n     (push_n),
    .push0      (res0),
    .push1      (res1),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .status     (qstat)
  );

  assign pop        = out_tvalid & out_tready;
  assign free_slots = 3'(QDEPTH) - 3'(qstat.cnt) + {2'b00, pop};
  assign adv        = s1_valid_r && ({1'b0, res_n} <= free_slots);
  assign push_n     = adv ? res_n : 2'd0;
  assign in_tready  = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r  <= in_tdata;
      in_final_r <= in_tlast;
    end
  end

  assign out_tvalid = head_valid;
  assign out_tdata  = {head.decoded_len, head.out_byte};
  assign out_tlast  = head.run_last;
  assign out_tuser  = {head.unknown_escape, head.bad_digit, head.string_end};

  // the queue never holds more than its depth
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.cnt <= QCNT_W'(QDEPTH))
    else $error("output queue overfilled");

  // a final byte leaves plain text and a cleared count behind
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_final_r) |=> (dstat.phase == PH_PLAIN && dstat.count_zero))
    else $error("state not cleared after string end");

  // two results only come out of a pending escape
  a_two_from_escape: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && res_n == 2'd2) |-> (dstat.phase == PH_ESC || dstat.phase == PH_HEX0))
    else $error("two results outside an escape");

  // a string end is always the last result of its byte
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tlast)
    else $error("string end without run last");

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import bhd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_ITEMS  = 340;
  localparam int PLAIN_LEN   = 40;

  typedef struct {
    logic [7:0] c;
    bit         fin;
    int         n;     // -1: take the predictor's results
    result_t    r0;
    result_t    r1;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] data_byte
  logic        in_tlast = 1'b0;    // is_final
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;          // [7:0] out_byte, [23:8] decoded_len
  logic        out_tlast;          // run_last
  logic [2:0]  out_tuser;          // [0] string_end, [1] bad_digit, [2] unknown_escape

  // decoder state as seen by the predictor
  phase_t      dec_phase = PH_PLAIN;
  logic [7:0]  first_digit = 8'h00;
  logic [15:0] byte_count = 16'h0000;

  result_t     expected_bytes[$];
  dir_row_t    dir_tbl[$];
  int          mismatch_cnt = 0;
  int          idle_cycles = 0;
  int          sent_rand = 0;
  bit          fast_mode = 1'b0;
  bit          hold_req = 1'b0;
  string       hex_chars = "0123456789abcdefABCDEF";

  backslash_hex_escape_decoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic result_t dec_result(logic [7:0] b, bit rl, bit se, bit bad, bit unk,
                                         logic [15:0] len);
    result_t r;
    r.out_byte       = b;
    r.run_last       = rl;
    r.string_end     = se;
    r.bad_digit      = bad;
    r.unknown_escape = unk;
    r.decoded_len    = len;
    return r;
  endfunction

  function automatic logic [3:0] hex_nibble(logic [7:0] c, inout bit bad);
    logic [3:0] v;
    v = 4'h0;
    if (c >= CH_0 && c <= CH_9) begin
      v = 4'(c - CH_0);
    end else if (c >= CH_LA && c <= CH_LF) begin
      v = 4'(c - CH_LA + 8'd10);
    end else if (c >= CH_UA && c <= CH_UF) begin
      v = 4'(c - CH_UA + 8'd10);
    end else begin
      bad = 1'b1;
    end
    return v;
  endfunction

  function automatic result_t emit_byte(logic [7:0] b, bit bad, bit unk);
    if (byte_count != COUNT_MAX) begin
      byte_count = byte_count + 16'd1;
    end
    return dec_result(b, 1'b0, 1'b0, bad, unk, byte_count);
  endfunction

  // advance the decoder by one request; returns the number of decoded bytes
  function automatic int decode_step(logic [7:0] c, bit fin, output result_t r0,
                                     output result_t r1);
    int n;
    bit bad;
    logic [3:0] hi;
    logic [3:0] lo;
    n = 0;
    bad = 1'b0;
    r0 = '0;
    r1 = '0;
    case (dec_phase)
      PH_PLAIN: begin
        if (c == CH_BSLASH && !fin) begin
          dec_phase = PH_ESC;
        end else begin
          r0 = emit_byte(c, 1'b0, 1'b0);
          n = 1;
        end
      end
      PH_ESC: begin
        dec_phase = PH_PLAIN;
        if (c == CH_BSLASH) begin
          r0 = emit_byte(CH_BSLASH, 1'b0, 1'b0);
          n = 1;
        end else if (c == CH_X) begin
          if (fin) begin
            r0 = emit_byte(CH_X, 1'b0, 1'b0);
            n = 1;
          end else begin
            dec_phase = PH_HEX0;
          end
        end else begin
          r0 = emit_byte(CH_BSLASH, 1'b0, 1'b1);
          r1 = emit_byte(c, 1'b0, 1'b0);
          n = 2;
        end
      end
      PH_HEX0: begin
        if (fin) begin
          // truncated escape: drop the backslash, pass the rest through
          r0 = emit_byte(CH_X, 1'b0, 1'b0);
          r1 = emit_byte(c, 1'b0, 1'b0);
          n = 2;
          dec_phase = PH_PLAIN;
        end else begin
          first_digit = c;
          dec_phase = PH_HEX1;
        end
      end
      default: begin
        hi = hex_nibble(first_digit, bad);
        lo = hex_nibble(c, bad);
        r0 = emit_byte({hi, lo}, bad, 1'b0);
        n = 1;
        first_digit = 8'h00;
        dec_phase = PH_PLAIN;
      end
    endcase
    if (n == 1) begin
      r0.run_last = 1'b1;
      r0.string_end = fin;
    end else if (n == 2) begin
      r1.run_last = 1'b1;
      r1.string_end = fin;
    end
    if (fin) begin
      dec_phase = PH_PLAIN;
      first_digit = 8'h00;
      byte_count = 16'h0000;
    end
    return n;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int g;
    if ($urandom_range(0, 9) < 8) begin
      g = $urandom_range(1, 3);
    end else begin
      g = $urandom_range(10, 40);
    end
    return g;
  endfunction

  function automatic void add_row(logic [7:0] c, bit fin, int n, result_t r0, result_t r1);
    dir_row_t row;
    row.c = c;
    row.fin = fin;
    row.n = n;
    row.r0 = r0;
    row.r1 = r1;
    dir_tbl.push_back(row);
  endfunction

  task automatic send_byte(logic [7:0] c, bit fin, int typed_n, result_t t0, result_t t1);
    int g;
    int n;
    result_t p0;
    result_t p1;
    g = 0;
    if (!fast_mode && $urandom_range(0, 9) >= 5) begin
      g = gap_len();
    end
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= fin;
    do @(posedge clk); while (!in_tready);
    n = decode_step(c, fin, p0, p1);
    if (typed_n >= 0) begin
      n = typed_n;
      p0 = t0;
      p1 = t1;
    end
    if (n > 0) begin
      expected_bytes.push_back(p0);
    end
    if (n > 1) begin
      expected_bytes.push_back(p1);
    end
  endtask

  task automatic send_random_string();
    logic [7:0] bytes_q[$];
    logic [7:0] c;
    int pick;
    int cut;
    repeat ($urandom_range(1, 8)) begin
      pick = $urandom_range(0, 99);
      c = 8'($urandom_range(0, 255));
      if (pick < 40) begin
        if (c == CH_BSLASH) begin
          c = c + 8'd1;
        end
        bytes_q.push_back(c);
      end else if (pick < 52) begin
        bytes_q.push_back(CH_BSLASH);
        bytes_q.push_back(CH_BSLASH);
      end else if (pick < 72) begin
        bytes_q.push_back(CH_BSLASH);
        bytes_q.push_back(CH_X);
        bytes_q.push_back(hex_chars[$urandom_range(0, 21)]);
        bytes_q.push_back(hex_chars[$urandom_range(0, 21)]);
      end else if (pick < 80) begin
        bytes_q.push_back(CH_BSLASH);
        bytes_q.push_back(CH_X);
        bytes_q.push_back(c);
        bytes_q.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 92) begin
        if (c == CH_BSLASH || c == CH_X) begin
          c = "k";
        end
        bytes_q.push_back(CH_BSLASH);
        bytes_q.push_back(c);
      end else begin
        bytes_q.push_back(c);
      end
    end
    // cut some strings short so escapes end at every phase
    if ($urandom_range(0, 3) == 0) begin
      cut = $urandom_range(1, bytes_q.size());
      while (bytes_q.size() > cut) begin
        void'(bytes_q.pop_back());
      end
    end
    foreach (bytes_q[i]) begin
      send_byte(bytes_q[i], i == bytes_q.size() - 1, -1, '0, '0);
    end
    sent_rand += bytes_q.size();
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      mismatch_cnt++;
      $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bytes.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected result, expected none, got byte %0h len %0h",
                 $time, out_tdata[7:0], out_tdata[23:8]);
      end else begin
        want = expected_bytes.pop_front();
        check_field("out_byte", want.out_byte, out_tdata[7:0]);
        check_field("decoded_len", want.decoded_len, out_tdata[23:8]);
        check_field("run_last", want.run_last, out_tlast);
        check_field("string_end", want.string_end, out_tuser[0]);
        check_field("bad_digit", want.bad_digit, out_tuser[1]);
        check_field("unknown_escape", want.unknown_escape, out_tuser[2]);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("tb failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    wait (rst_n);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (fast_mode || $urandom_range(0, 2) != 0) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end
    end
  end

  initial begin
    int next_hold;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    add_row("A", 1'b0, 1, dec_result("A", 1, 0, 0, 0, 16'd1), '0);
    add_row(8'h00, 1'b0, 1, dec_result(8'h00, 1, 0, 0, 0, 16'd2), '0);
    add_row(8'hFF, 1'b0, 1, dec_result(8'hFF, 1, 0, 0, 0, 16'd3), '0);
    add_row(CH_BSLASH, 1'b0, 0, '0, '0);
    add_row(CH_BSLASH, 1'b0, 1, dec_result(CH_BSLASH, 1, 0, 0, 0, 16'd4), '0);
    // both digits invalid
    add_row(CH_BSLASH, 1'b0, -1, '0, '0);
    add_row(CH_X, 1'b0, 0, '0, '0);
    add_row("g", 1'b0, 0, '0, '0);
    add_row("Z", 1'b0, 1, dec_result(8'h00, 1, 0, 1, 0, 16'd5), '0);
    // unknown specifier keeps the backslash
    add_row(CH_BSLASH, 1'b0, -1, '0, '0);
    add_row("q", 1'b0, 2, dec_result(CH_BSLASH, 0, 0, 0, 1, 16'd6),
            dec_result("q", 1, 0, 0, 0, 16'd7));
    // lone backslash at the end of the string
    add_row(CH_BSLASH, 1'b1, 1, dec_result(CH_BSLASH, 1, 1, 0, 0, 16'd8), '0);
    // string ends right after the x
    add_row(CH_BSLASH, 1'b0, -1, '0, '0);
    add_row(CH_X, 1'b1, 1, dec_result(CH_X, 1, 1, 0, 0, 16'd1), '0);
    // string ends on the first digit
    add_row(CH_BSLASH, 1'b0, -1, '0, '0);
    add_row(CH_X, 1'b0, -1, '0, '0);
    add_row("7", 1'b1, 2, dec_result(CH_X, 0, 0, 0, 0, 16'd1),
            dec_result("7", 1, 1, 0, 0, 16'd2));
    // second digit is the last byte
    add_row(CH_BSLASH, 1'b0, -1, '0, '0);
    add_row(CH_X, 1'b0, -1, '0, '0);
    add_row("a", 1'b0, -1, '0, '0);
    add_row("F", 1'b1, 1, dec_result(8'hAF, 1, 1, 0, 0, 16'd1), '0);
    add_row(CH_BSLASH, 1'b0, -1, '0, '0);
    add_row("z", 1'b1, 2, dec_result(CH_BSLASH, 0, 0, 0, 1, 16'd1),
            dec_result("z", 1, 1, 0, 0, 16'd2));

    foreach (dir_tbl[i]) begin
      send_byte(dir_tbl[i].c, dir_tbl[i].fin, dir_tbl[i].n, dir_tbl[i].r0, dir_tbl[i].r1);
    end

    // one plain string sent back to back
    fast_mode = 1'b1;
    for (int i = 0; i < PLAIN_LEN; i++) begin
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      if (c == CH_BSLASH) begin
        c = "s";
      end
      send_byte(c, i == PLAIN_LEN - 1, -1, '0, '0);
    end

    next_hold = 100;
    while (sent_rand < RAND_ITEMS) begin
      if (sent_rand >= next_hold && next_hold < RAND_ITEMS) begin
        hold_req = 1'b1;
        next_hold += 200;
      end
      fast_mode = ($urandom_range(0, 7) == 0);
      send_random_string();
    end
    in_tvalid <= 1'b0;
    fast_mode = 1'b0;

    while (expected_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

### backslash_hex_escape_decoder.f
hdl/bhd_pkg.sv
hdl/bhd_decode.sv
hdl/bhd_outq.sv
hdl/backslash_hex_escape_decoder.sv
verif/tb.sv
